// ===== rtl/multiplexed_servo_pulse_generator_assert.svh =====
// ----------------------------------------------------------------------------
// Servo pulse generator assertion macros
// Shared forms for the concurrent checks of the servo pulse generator.
// ----------------------------------------------------------------------------
`ifndef MULTIPLEXED_SERVO_PULSE_GENERATOR_ASSERT_SVH
`define MULTIPLEXED_SERVO_PULSE_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MSP_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("servo pulse generator check failed");

// Next-cycle implication, checked outside reset.
`define MSP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("servo pulse generator check failed");

// Implication that also holds during reset.
`define MSP_ASSERT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |-> (cons)) \
    else $error("servo pulse generator check failed");

`endif

// ===== rtl/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo pulse generator package
// Widths, defaults, codes and shared types of the servo pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

  localparam int SERVO_COUNT_DEF  = 8;
  localparam int SLOT_TICKS_DEF   = 250;
  localparam int TICKS_PER_MS_DEF = 100;

  localparam int OPC_W = 1;
  localparam int IDX_W = 4;
  localparam int PWD_W = 10;
  localparam int PIN_W = 8;
  localparam int ST_W  = 2;
  localparam int CD_W  = 22;

  localparam logic [OPC_W-1:0] OPC_TICK = 1'b0;
  localparam logic [OPC_W-1:0] OPC_SET  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_BAD_WIDTH = 2'd2
  } msp_status_t;

  // Broadcast to every servo cell.
  typedef struct packed {
    logic            ms_tick;
    logic            slot_adv;
    logic [CD_W-1:0] timeout;
  } msp_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/msp_ifs.sv =====
// ----------------------------------------------------------------------------
// Servo pulse generator channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface msp_item_if import msp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [IDX_W-1:0] servo_index;
  logic [PWD_W-1:0] pulse_width;

  modport source (output valid, output opcode, output servo_index, output pulse_width,
                  input ready);
  modport sink   (input valid, input opcode, input servo_index, input pulse_width,
                  output ready);
endinterface

interface msp_result_if import msp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIN_W-1:0] pin_levels;
  logic [ST_W-1:0]  status;

  modport source (output valid, output pin_levels, output status, input ready);
  modport sink   (input valid, input pin_levels, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/multiplexed_servo_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// Multiplexed servo pulse generator
// Time-slots a servo frame over a ring of servo cells and drives one pin
// per servo; set commands store widths with an optional idle timeout.
// ----------------------------------------------------------------------------
//   Channel   Dir   Handshake      Payload
//   item      in    valid/ready    opcode, servo_index, pulse_width
//   result    out   valid/ready    pin_levels, status
//   wr_*      in    write enable   wr_data = idle_timeout_ms
//
// One item is taken per cycle while ready is high; its result is registered.
// All cell updates finish in the accepting cycle, so items follow back to back.
// A two-entry result buffer keeps input ready high until two results wait.
// Synchronous reset clears all state but buffer data; no clearing pass needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplexed_servo_pulse_generator import msp_pkg::*; #(
  parameter int SERVO_COUNT  = SERVO_COUNT_DEF,
  parameter int SLOT_TICKS   = SLOT_TICKS_DEF,
  parameter int TICKS_PER_MS = TICKS_PER_MS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  msp_item_if.sink             item,
  msp_result_if.source         result,
  input  wire logic            wr_en,
  input  wire logic [CD_W-1:0] wr_data
);

  localparam int OFF_W = $clog2(SLOT_TICKS);
  localparam int PRE_W = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;

  logic [CD_W-1:0]        timeout;
  logic [PRE_W-1:0]       prescaler;
  logic [OFF_W-1:0]       offset;
  logic [PIN_W-1:0]       pin_level_bits;
  logic                   accept, is_tick, tick;
  logic                   pre_wrap, off_wrap;
  logic                   idx_bad, width_bad, set_ok;
  logic                   space;
  msp_cell_ctrl_t         ctrl;
  logic [SERVO_COUNT-1:0] tokens, pins;
  logic [PIN_W-1:0]       res_pins;
  msp_status_t            res_status;

  assign accept    = item.valid && item.ready;
  assign item.ready = space;
  assign is_tick   = (item.opcode == OPC_TICK);
  assign tick      = accept && is_tick;
  assign pre_wrap  = (prescaler == PRE_W'(TICKS_PER_MS - 1));
  assign off_wrap  = (offset == OFF_W'(SLOT_TICKS - 1));
  assign idx_bad   = (item.servo_index >= IDX_W'(SERVO_COUNT));
  assign width_bad = (item.pulse_width > PWD_W'(SLOT_TICKS - 1));
  assign set_ok    = accept && !is_tick && !idx_bad && !width_bad;

  assign ctrl.ms_tick  = tick && pre_wrap;
  assign ctrl.slot_adv = tick && off_wrap;
  assign ctrl.timeout  = timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout        <= '0;
      prescaler      <= '0;
      offset         <= '0;
      pin_level_bits <= '0;
    end else begin
      if (wr_en) begin
        timeout <= wr_data;
      end
      if (tick) begin
        prescaler      <= pre_wrap ? '0 : prescaler + PRE_W'(1);
        offset         <= off_wrap ? '0 : offset + OFF_W'(1);
        pin_level_bits <= res_pins;
      end
    end
  end

  // The slot token travels around the ring; cell zero holds it after reset.
  for (genvar i = 0; i < SERVO_COUNT; i++) begin : g_cell
    localparam int PREV = (i == 0) ? SERVO_COUNT - 1 : i - 1;

    msp_servo_cell #(
      .WIDTH_W     (OFF_W),
      .FIRST_TOKEN (i == 0)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .set_en    (set_ok && (item.servo_index == IDX_W'(i))),
      .set_width (item.pulse_width[OFF_W-1:0]),
      .offset    (offset),
      .token_in  (tokens[PREV]),
      .token_out (tokens[i]),
      .pin       (pins[i])
    );
  end

  always_comb begin
    res_pins   = pin_level_bits;
    res_status = ST_OK;
    if (is_tick) begin
      res_pins = PIN_W'(pins);
    end else if (idx_bad) begin
      res_status = ST_BAD_INDEX;
    end else if (width_bad) begin
      res_status = ST_BAD_WIDTH;
    end
  end

  msp_result_buf u_buf (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .push_pins   (res_pins),
    .push_status (res_status),
    .space       (space),
    .result      (result)
  );

endmodule

`default_nettype wire

// ===== rtl/msp_servo_cell.sv =====
// ----------------------------------------------------------------------------
// Servo cell
// Holds one servo's width and idle countdown, and the slot token that moves
// to the next cell at each slot boundary.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_servo_cell import msp_pkg::*; #(
  parameter int   WIDTH_W     = 8,
  parameter logic FIRST_TOKEN = 1'b0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire msp_cell_ctrl_t     ctrl,
  input  wire logic               set_en,
  input  wire logic [WIDTH_W-1:0] set_width,
  input  wire logic [WIDTH_W-1:0] offset,
  input  wire logic               token_in,
  output logic                    token_out,
  output logic                    pin
);

  logic [WIDTH_W-1:0] width;
  logic [CD_W-1:0]    countdown;
  logic               token;
  logic               expire;
  logic [WIDTH_W-1:0] width_eff;

  // A countdown at one that sees a millisecond clears the width on this tick.
  assign expire    = ctrl.ms_tick && (countdown == CD_W'(1));
  assign width_eff = expire ? '0 : width;
  assign pin       = token && (offset < width_eff);
  assign token_out = token;

  always_ff @(posedge clk) begin
    if (rst) begin
      width     <= '0;
      countdown <= '0;
      token     <= FIRST_TOKEN;
    end else begin
      if (set_en) begin
        width <= set_width;
        if ((set_width != '0) && (ctrl.timeout != '0)) begin
          countdown <= ctrl.timeout;
        end
      end else if (ctrl.ms_tick && (countdown != '0)) begin
        countdown <= countdown - CD_W'(1);
        if (expire) begin
          width <= '0;
        end
      end
      if (ctrl.slot_adv) begin
        token <= token_in;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/msp_result_buf.sv =====
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry output buffer that lets the block take an item while a result
// is still waiting downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_result_buf import msp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [PIN_W-1:0] push_pins,
  input  wire logic [ST_W-1:0]  push_status,
  output logic                  space,
  msp_result_if.source          result
);

  logic [1:0]       count;
  logic [PIN_W-1:0] pins0, pins1;
  logic [ST_W-1:0]  stat0, stat1;
  logic             pop;

  assign pop               = result.valid && result.ready;
  assign space             = (count != 2'd2);
  assign result.valid      = (count != 2'd0);
  assign result.pin_levels = pins0;
  assign result.status     = stat0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pins0 <= pins1;
      stat0 <= stat1;
    end
    // Entry zero takes a new item when it is empty after this edge.
    if (push && ((count == 2'd0) || ((count == 2'd1) && pop))) begin
      pins0 <= push_pins;
      stat0 <= push_status;
    end
    if (push && (((count == 2'd1) && !pop) || (count == 2'd2))) begin
      pins1 <= push_pins;
      stat1 <= push_status;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/msp_checker.sv =====
// ----------------------------------------------------------------------------
// Servo pulse generator checker
// Port-level checks of the servo pulse generator, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multiplexed_servo_pulse_generator_assert.svh"

module msp_checker import msp_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_ready,
  input wire logic             res_valid,
  input wire logic             res_ready,
  input wire logic [PIN_W-1:0] res_pins,
  input wire logic [ST_W-1:0]  res_status
);

  // Only the servo of the active slot can be high.
  `MSP_ASSERT_NOW(a_one_pin, clk, rst, res_valid, $onehot0(res_pins))
  `MSP_ASSERT_NOW(a_status_code, clk, rst, res_valid, res_status <= ST_BAD_WIDTH)
  // Every accepted item leaves a result waiting on the next cycle.
  `MSP_ASSERT_NEXT(a_item_gives_result, clk, rst, item_valid && item_ready, res_valid)
  `MSP_ASSERT_NEXT(a_result_held, clk, rst, res_valid && !res_ready, res_valid)
  `MSP_ASSERT_ALWAYS(a_empty_after_reset, clk, $past(rst), !res_valid)

endmodule

bind multiplexed_servo_pulse_generator msp_checker u_msp_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_pins   (result.pin_levels),
  .res_status (result.status)
);

`default_nettype wire
